[rtl/intc_regs_pkg.sv]
// Shared types and constants for the interrupt controller register block.
// No dependencies; used by the top level and its port checker.
package intc_regs_pkg;

   typedef enum logic [2:0] {
      CMD_READ_WORD  = 3'd0,
      CMD_WRITE_WORD = 3'd1,
      CMD_READ_BYTE  = 3'd2,
      CMD_WRITE_BYTE = 3'd3,
      CMD_ASSERT     = 3'd4,
      CMD_DEASSERT   = 3'd5
   } cmd_type;

   localparam logic [7:0] OFF_ICIP  = 8'h00;
   localparam logic [7:0] OFF_MASK  = 8'h04;
   localparam logic [7:0] OFF_LEVEL = 8'h08;
   localparam logic [7:0] OFF_ICFP  = 8'h0C;
   localparam logic [7:0] OFF_PEND  = 8'h10;
   localparam logic [7:0] OFF_CTRL  = 8'h14;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

endpackage

[rtl/interrupt_controller_regs_top.sv]
// Interrupt controller register block: pending, mask, level and control registers.
// Depends on intc_regs_pkg; intc_regs_checker binds to it.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  req     | in  | reg_offset 8, write_data 32, source_index 5, pad 3  | cmd 3
//  rsp     | out | read_data 32, irq_line 1, fiq_line 1, pad 6         | bad_access 1
//
// One request per cycle unless stalled; each gives one response in the cycle after acceptance.
// The response register is the only stage: state and response update at the same edge.
// A stalled response holds; req_tready follows rsp_tready while a response waits.
// reset (synchronous) clears the state registers and rsp_tvalid; req_tready is low during reset.
module interrupt_controller_regs_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [7:0] reg_offset, [39:8] write_data, [44:40] source_index, [47:45] zero
   input  logic [intc_regs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] cmd
   input  logic [2:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [31:0] read_data, [32] irq_line, [33] fiq_line, [39:34] zero
   output logic [intc_regs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] bad_access
   output logic [0:0]                             rsp_tuser
);
   import intc_regs_pkg::*;

   logic [31:0] pending_ff, pending_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] level_ff, level_in;
   logic        ctrl_ff, ctrl_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] read_data_ff, read_data_in;
   logic        irq_ff, irq_in;
   logic        fiq_ff, fiq_in;
   logic        bad_ff, bad_in;

   logic        accept;
   cmd_type     cmd;
   logic [7:0]  offset;
   logic [31:0] wdata;
   logic [4:0]  src;
   logic [7:0]  base;
   logic [4:0]  shift;
   logic        word_known;
   logic        base_known;
   logic [31:0] word_val;
   logic [31:0] base_val;
   logic [31:0] merged;

   function automatic logic [31:0] reg_read(input logic [7:0] off, input logic [31:0] pend,
                                            input logic [31:0] msk, input logic [31:0] lvl,
                                            input logic ctl);
      case (off)
         OFF_ICIP:  reg_read = pend & msk & ~lvl;
         OFF_MASK:  reg_read = msk;
         OFF_LEVEL: reg_read = lvl;
         OFF_ICFP:  reg_read = pend & msk & lvl;
         OFF_PEND:  reg_read = pend;
         OFF_CTRL:  reg_read = {31'd0, ctl};
         default:   reg_read = 32'd0;
      endcase
   endfunction

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign cmd    = cmd_type'(req_tuser);
   assign offset = req_tdata[7:0];
   assign wdata  = req_tdata[39:8];
   assign src    = req_tdata[44:40];
   assign base   = {offset[7:2], 2'b00};
   assign shift  = {offset[1:0], 3'b000};

   assign word_known = (offset[1:0] == 2'b00) && (offset <= OFF_CTRL);
   assign base_known = (base <= OFF_CTRL);
   assign word_val   = reg_read(offset, pending_ff, mask_ff, level_ff, ctrl_ff);
   assign base_val   = reg_read(base, pending_ff, mask_ff, level_ff, ctrl_ff);
   assign merged     = (base_val & ~(32'hFF << shift)) | ({24'd0, wdata[7:0]} << shift);

   always_comb begin
      pending_in   = pending_ff;
      mask_in      = mask_ff;
      level_in     = level_ff;
      ctrl_in      = ctrl_ff;
      read_data_in = 32'd0;
      bad_in       = 1'b0;
      case (cmd)
         CMD_READ_WORD: begin
            if (word_known) read_data_in = word_val;
            else bad_in = 1'b1;
         end
         CMD_WRITE_WORD: begin
            if (word_known) begin
               case (offset)
                  OFF_MASK:  mask_in  = wdata;
                  OFF_LEVEL: level_in = wdata;
                  OFF_CTRL:  ctrl_in  = wdata[0];
                  default:   ;
               endcase
            end else begin
               bad_in = 1'b1;
            end
         end
         CMD_READ_BYTE: begin
            if (base_known) read_data_in = {24'd0, 8'(base_val >> shift)};
            else bad_in = 1'b1;
         end
         CMD_WRITE_BYTE: begin
            if (base_known) begin
               case (base)
                  OFF_MASK:  mask_in  = merged;
                  OFF_LEVEL: level_in = merged;
                  OFF_CTRL:  ctrl_in  = merged[0];
                  default:   ;
               endcase
            end else begin
               bad_in = 1'b1;
            end
         end
         CMD_ASSERT:   pending_in = pending_ff | (32'd1 << src);
         CMD_DEASSERT: pending_in = pending_ff & ~(32'd1 << src);
         default:      ;
      endcase
      irq_in = |(pending_in & mask_in & ~level_in);
      fiq_in = |(pending_in & mask_in & level_in);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 32'd0;
         mask_ff      <= 32'd0;
         level_ff     <= 32'd0;
         ctrl_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pending_ff <= pending_in;
            mask_ff    <= mask_in;
            level_ff   <= level_in;
            ctrl_ff    <= ctrl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
         fiq_ff       <= fiq_in;
         bad_ff       <= bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, fiq_ff, irq_ff, read_data_ff};
   assign rsp_tuser  = bad_ff;

endmodule

[rtl/intc_regs_checker.sv]
// Port-level checker for interrupt_controller_regs_top, with its bind statement.
// Depends on intc_regs_pkg for command codes and channel widths.
module intc_regs_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tvalid,
   input logic                                   req_tready,
   input logic [2:0]                             req_tuser,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [intc_regs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [0:0]                             rsp_tuser
);
   import intc_regs_pkg::*;

   logic req_acc;
   logic src_event;
   logic non_read;

   assign req_acc   = req_tvalid && req_tready;
   assign src_event = (req_tuser == CMD_ASSERT) || (req_tuser == CMD_DEASSERT);
   assign non_read  = (req_tuser != CMD_READ_WORD) && (req_tuser != CMD_READ_BYTE);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_tvalid)
      else $error("accepted request gave no response");

   a_src_ok: assert property (@(posedge clock) disable iff (reset)
      req_acc && src_event |=> rsp_tuser[0] == 1'b0)
      else $error("source event flagged as bad access");

   a_no_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_acc && non_read |=> rsp_tdata[31:0] == 32'd0)
      else $error("non-read request returned data");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("bad access returned data");

endmodule

bind interrupt_controller_regs_top intc_regs_checker u_intc_regs_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for interrupt_controller_regs_top: register access, source events.
// Keeps a shadow copy of the controller registers and checks every response against it.
// Depends on intc_regs_pkg and the interrupt_controller_regs_top RTL.
module testbench;
   import intc_regs_pkg::*;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 185;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_line;
      logic        fiq_line;
      logic        bad_access;
   } intc_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [2:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [0:0]              rsp_tuser;

   logic [31:0] shadow_pending = '0;
   logic [31:0] shadow_mask = '0;
   logic [31:0] shadow_level = '0;
   logic        shadow_idle_enable = 1'b0;

   intc_rsp_type rsp_due_q[$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int bad_seen = 0;
   int irq_seen = 0;
   int fiq_seen = 0;
   int idle_cycles = 0;

   logic [7:0] reg_offsets [6] = '{OFF_ICIP, OFF_MASK, OFF_LEVEL, OFF_ICFP, OFF_PEND, OFF_CTRL};

   interrupt_controller_regs_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] shadow_read(logic [7:0] off);
      case (off)
         OFF_ICIP:  return shadow_pending & shadow_mask & ~shadow_level;
         OFF_MASK:  return shadow_mask;
         OFF_LEVEL: return shadow_level;
         OFF_ICFP:  return shadow_pending & shadow_mask & shadow_level;
         OFF_PEND:  return shadow_pending;
         OFF_CTRL:  return {31'd0, shadow_idle_enable};
         default:   return 32'd0;
      endcase
   endfunction

   function automatic void shadow_write(logic [7:0] off, logic [31:0] value);
      case (off)
         OFF_MASK:  shadow_mask = value;
         OFF_LEVEL: shadow_level = value;
         OFF_CTRL:  shadow_idle_enable = value[0];
         default: ;
      endcase
   endfunction

   function automatic bit offset_known(logic [7:0] off);
      return off[1:0] == 2'b00 && off <= OFF_CTRL;
   endfunction

   function automatic intc_rsp_type shadow_apply(logic [2:0] cmd, logic [7:0] off,
                                                 logic [31:0] data, logic [4:0] src);
      intc_rsp_type r;
      logic [7:0]   base;
      int           shift;
      logic [31:0]  merged;
      r = '0;
      base = {off[7:2], 2'b00};
      shift = off[1:0] * 8;
      case (cmd)
         CMD_READ_WORD:
            if (offset_known(off)) r.read_data = shadow_read(off);
            else r.bad_access = 1'b1;
         CMD_WRITE_WORD:
            if (offset_known(off)) shadow_write(off, data);
            else r.bad_access = 1'b1;
         CMD_READ_BYTE:
            if (offset_known(base)) r.read_data = (shadow_read(base) >> shift) & 32'hFF;
            else r.bad_access = 1'b1;
         CMD_WRITE_BYTE:
            if (offset_known(base)) begin
               merged = (shadow_read(base) & ~(32'hFF << shift)) | ((data & 32'hFF) << shift);
               shadow_write(base, merged);
            end else begin
               r.bad_access = 1'b1;
            end
         CMD_ASSERT:   shadow_pending[src] = 1'b1;
         CMD_DEASSERT: shadow_pending[src] = 1'b0;
         default: ;
      endcase
      r.irq_line = |(shadow_pending & shadow_mask & ~shadow_level);
      r.fiq_line = |(shadow_pending & shadow_mask & shadow_level);
      return r;
   endfunction

   task automatic send_request(logic [2:0] cmd, logic [7:0] off, logic [31:0] data,
                               logic [4:0] src);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, src, data, off};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      rsp_due_q.push_back(shadow_apply(cmd, off, data, src));
      requests_sent++;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      intc_rsp_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due_q.size() == 0) begin
            $error("response with no request outstanding: tdata 0x%010h", rsp_tdata);
            mismatches++;
         end else begin
            exp_r = rsp_due_q.pop_front();
            compare_field("read_data", exp_r.read_data, rsp_tdata[31:0]);
            compare_field("irq_line", 32'(exp_r.irq_line), 32'(rsp_tdata[32]));
            compare_field("fiq_line", 32'(exp_r.fiq_line), 32'(rsp_tdata[33]));
            compare_field("bad_access", 32'(exp_r.bad_access), 32'(rsp_tuser[0]));
            responses_checked++;
            bad_seen += int'(rsp_tuser[0]);
            irq_seen += int'(rsp_tdata[32]);
            fiq_seen += int'(rsp_tdata[33]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_reset_values();
      foreach (reg_offsets[i])
         send_request(CMD_READ_WORD, reg_offsets[i], 32'd0, 5'd0);
   endtask

   task automatic test_directed_access();
      send_request(CMD_WRITE_WORD, OFF_MASK, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_WRITE_WORD, OFF_LEVEL, 32'h8000_0001, 5'd0);
      send_request(CMD_ASSERT, 8'h00, 32'd0, 5'd0);
      send_request(CMD_ASSERT, 8'h00, 32'd0, 5'd31);
      send_request(CMD_ASSERT, 8'h00, 32'd0, 5'd5);
      send_request(CMD_ASSERT, 8'h00, 32'd0, 5'd5);
      send_request(CMD_READ_WORD, OFF_ICIP, 32'd0, 5'd0);
      send_request(CMD_READ_WORD, OFF_ICFP, 32'd0, 5'd0);
      send_request(CMD_READ_WORD, OFF_PEND, 32'd0, 5'd0);
      send_request(CMD_WRITE_BYTE, OFF_MASK + 8'd3, 32'hFFFF_FF00, 5'd0);
      send_request(CMD_READ_BYTE, OFF_LEVEL + 8'd3, 32'd0, 5'd0);
      send_request(CMD_WRITE_WORD, OFF_CTRL, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_WRITE_BYTE, OFF_CTRL + 8'd1, 32'h0000_00FE, 5'd0);
      send_request(CMD_READ_WORD, OFF_CTRL, 32'd0, 5'd0);
      send_request(CMD_WRITE_WORD, OFF_ICIP, 32'h1234_5678, 5'd0);
      send_request(CMD_WRITE_BYTE, OFF_PEND, 32'h0000_00FF, 5'd0);
      send_request(CMD_READ_WORD, 8'h02, 32'd0, 5'd0);
      send_request(CMD_WRITE_WORD, 8'hFC, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_WRITE_BYTE, 8'h1B, 32'h0000_00FF, 5'd0);
      send_request(CMD_READ_BYTE, 8'hFF, 32'd0, 5'd0);
      send_request(CMD_DEASSERT, 8'h00, 32'd0, 5'd31);
      send_request(CMD_DEASSERT, 8'h00, 32'd0, 5'd31);
      send_request(CMD_SPARE_6, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      send_request(CMD_SPARE_7, 8'h00, 32'd0, 5'd0);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
      int          k;
      logic [2:0]  cmd;
      logic [7:0]  off;
      logic [31:0] data;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         k = $urandom_range(99);
         if (k < 14) cmd = CMD_READ_WORD;
         else if (k < 28) cmd = CMD_WRITE_WORD;
         else if (k < 42) cmd = CMD_READ_BYTE;
         else if (k < 54) cmd = CMD_WRITE_BYTE;
         else if (k < 75) cmd = CMD_ASSERT;
         else if (k < 96) cmd = CMD_DEASSERT;
         else cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
         if ($urandom_range(99) >= 88)
            off = 8'($urandom_range(255));
         else if (cmd == CMD_READ_BYTE || cmd == CMD_WRITE_BYTE)
            off = 8'($urandom_range(OFF_CTRL + 3));
         else
            off = reg_offsets[$urandom_range(5)];
         case ($urandom_range(9))
            0: data = 32'd0;
            1: data = 32'hFFFF_FFFF;
            default: data = $urandom;
         endcase
         send_request(cmd, off, data, 5'($urandom_range(31)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_access();
      test_random_traffic(0, 0, RANDOM_PER_PHASE);
      test_random_traffic(76, 0, RANDOM_PER_PHASE);
      test_random_traffic(0, 76, RANDOM_PER_PHASE);
      test_random_traffic(32, 32, RANDOM_PER_PHASE);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Covered %0d requests (word/byte access, source events, spare commands),",
               requests_sent);
      $display("%0d responses checked.", responses_checked);
      $display("Responses with bad_access: %0d, irq_line high: %0d, fiq_line high: %0d.",
               bad_seen, irq_seen, fiq_seen);
      if (mismatches == 0 && rsp_due_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
